### rtl/tqrr_pkg.sv
// Package for the three-queue round-robin task scheduler.
// Holds sizes, codes, controller/datapath command and status types.
// No dependencies.
package tqrr_pkg;

    localparam int SLOTS_PER_QUEUE    = 15;
    localparam int PLAYER_QUEUE_SLOTS = 5;
    localparam int PROBE_LIMIT        = 46;
    localparam int IDLE_SELECTOR      = 80;
    localparam int QUEUE_COUNT        = 3;
    localparam int TOTAL_SLOTS        = QUEUE_COUNT * SLOTS_PER_QUEUE;

    localparam int SLOT_W  = $clog2(SLOTS_PER_QUEUE);
    localparam int HINT_W  = $clog2(PLAYER_QUEUE_SLOTS + 1);
    localparam int ADDR_W  = $clog2(TOTAL_SLOTS);
    localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);
    localparam int QUEUE_W = 2;
    localparam int SEL_W   = 16;
    localparam int PB_W    = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    localparam logic [QUEUE_W-1:0] Q_FIRST   = 2'd0;
    localparam logic [QUEUE_W-1:0] Q_SECOND  = 2'd1;
    localparam logic [QUEUE_W-1:0] Q_NEUTRAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic found;
        logic [SLOT_W-1:0] slot;
    } t_pick;

    typedef struct packed {
        logic take;        // latch the accepted item and clear the result
        logic res_halt;    // answer an item that arrives while halted
        logic load_place;  // place a task and, for the first queue, update its hint
        logic probe;       // one probe of the schedule walk
        logic compare;     // take the read slot as the running task
        logic halt;        // probe limit reached
        logic emit;        // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic halted;
        logic is_load;
        logic probe_present;
        logic limit_hit;
        logic differs;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [QUEUE_W-1:0] q,
        input logic [SLOT_W-1:0]  s
    );
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(q) * ADDR_W'(SLOTS_PER_QUEUE);
        return base + ADDR_W'(s);
    endfunction

endpackage

### rtl/tqrr_if.sv
// Valid/ready channel interfaces for the task scheduler: the input item
// channel and the result channel. Depends on tqrr_pkg.
interface tqrr_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic [tqrr_pkg::QUEUE_W-1:0] queue_select;
    logic [tqrr_pkg::SEL_W-1:0]   task_selector;
    logic [tqrr_pkg::PB_W-1:0]    page_base;

    modport source (output valid, opcode, queue_select, task_selector, page_base,
                    input ready);
    modport sink (input valid, opcode, queue_select, task_selector, page_base,
                  output ready);
endinterface

interface tqrr_out_if;
    logic valid;
    logic ready;
    logic [tqrr_pkg::SEL_W-1:0]      chosen_selector;
    logic [tqrr_pkg::SLOT_OUT_W-1:0] slot_used;
    logic [tqrr_pkg::STATUS_W-1:0]   status;

    modport source (output valid, chosen_selector, slot_used, status, input ready);
    modport sink (input valid, chosen_selector, slot_used, status, output ready);
endinterface

### rtl/tqrr_ctrl.sv
// Controller state machine of the task scheduler: sequences accept,
// decode, the probe/compare walk and result hand-off. Depends on tqrr_pkg.
module tqrr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tqrr_pkg::t_dp_stat  i_stat,
    output tqrr_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_PROBE  = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.halted) begin
                    o_cmd.res_halt = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.is_load) begin
                    o_cmd.load_place = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_stat.limit_hit) begin
                    o_cmd.halt = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.probe = 1'b1;
                    // A present slot needs its stored task read before comparing.
                    if (i_stat.probe_present) begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state = i_stat.differs ? S_DONE : S_PROBE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/tqrr_dp.sv
// Datapath of the task scheduler: slot presence bits, slot task memory,
// queue indices, running task, hint, halt flag and the output register.
// Depends on tqrr_pkg.
module tqrr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tqrr_pkg::t_dp_cmd                  i_cmd,
    output tqrr_pkg::t_dp_stat                 o_stat,
    input  logic                               i_opcode,
    input  logic [tqrr_pkg::QUEUE_W-1:0]       i_queue_select,
    input  logic [tqrr_pkg::SEL_W-1:0]         i_task_selector,
    input  logic [tqrr_pkg::PB_W-1:0]          i_page_base,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tqrr_pkg::SEL_W-1:0]         o_chosen_selector,
    output logic [tqrr_pkg::SLOT_OUT_W-1:0]    o_slot_used,
    output logic [tqrr_pkg::STATUS_W-1:0]      o_status
);

    localparam int S = tqrr_pkg::SLOTS_PER_QUEUE;

    // Control state.
    logic [tqrr_pkg::QUEUE_COUNT-1:0][S-1:0]                r_present;
    logic [tqrr_pkg::QUEUE_COUNT-1:0][tqrr_pkg::SLOT_W-1:0] r_next_idx;
    logic [tqrr_pkg::QUEUE_W-1:0]  r_cur_q;
    logic [tqrr_pkg::SEL_W-1:0]    r_run_sel;
    logic [tqrr_pkg::PB_W-1:0]     r_run_pb;
    logic [tqrr_pkg::HINT_W-1:0]   r_hint;
    logic                          r_halted;
    logic [tqrr_pkg::PROBE_W-1:0]  r_probes;
    logic                          r_out_valid;

    // Payload.
    logic                          r_op;
    logic [tqrr_pkg::QUEUE_W-1:0]  r_q;
    logic [tqrr_pkg::SEL_W-1:0]    r_sel;
    logic [tqrr_pkg::PB_W-1:0]     r_pb;
    logic [tqrr_pkg::SEL_W-1:0]    r_old_sel;
    logic [tqrr_pkg::PB_W-1:0]     r_old_pb;
    logic [tqrr_pkg::SLOT_W-1:0]   r_noted;
    logic [tqrr_pkg::SEL_W-1:0]    r_res_sel;
    logic [tqrr_pkg::SLOT_W-1:0]   r_res_slot;
    logic [tqrr_pkg::STATUS_W-1:0] r_res_status;
    logic [tqrr_pkg::SEL_W-1:0]    r_out_sel;
    logic [tqrr_pkg::SLOT_W-1:0]   r_out_slot;
    logic [tqrr_pkg::STATUS_W-1:0] r_out_status;
    logic [tqrr_pkg::SEL_W-1:0]    r_rd_sel;
    logic [tqrr_pkg::PB_W-1:0]     r_rd_pb;

    // Slot task memory.
    logic [tqrr_pkg::SEL_W-1:0] r_mem_sel [tqrr_pkg::TOTAL_SLOTS];
    logic [tqrr_pkg::PB_W-1:0]  r_mem_pb  [tqrr_pkg::TOTAL_SLOTS];

    function automatic tqrr_pkg::t_pick lowest_free(input logic [S-1:0] row, input int limit);
        tqrr_pkg::t_pick p;
        p = '0;
        for (int k = S - 1; k >= 0; k--) begin
            if (k < limit && !row[k]) begin
                p.found = 1'b1;
                p.slot  = tqrr_pkg::SLOT_W'(k);
            end
        end
        return p;
    endfunction

    function automatic tqrr_pkg::t_pick first_pick(
        input logic [S-1:0] row,
        input logic [tqrr_pkg::HINT_W-1:0] hint
    );
        tqrr_pkg::t_pick p;
        logic [tqrr_pkg::SLOT_W-1:0] pref;
        if (hint == tqrr_pkg::HINT_W'(tqrr_pkg::PLAYER_QUEUE_SLOTS - 1)) begin
            pref = '0;
        end else begin
            pref = tqrr_pkg::SLOT_W'(hint) + tqrr_pkg::SLOT_W'(1);
        end
        if (!row[pref]) begin
            p.found = 1'b1;
            p.slot  = pref;
        end else begin
            p = lowest_free(row, tqrr_pkg::PLAYER_QUEUE_SLOTS);
        end
        return p;
    endfunction

    // Load placement.
    tqrr_pkg::t_pick              load_pick;
    tqrr_pkg::t_pick              hint_pick;
    logic                         load_q_valid;
    logic [S-1:0]                 row_after;
    logic [tqrr_pkg::HINT_W-1:0]  hint_next;
    logic [tqrr_pkg::ADDR_W-1:0]  load_addr;
    logic                         load_write;

    always_comb begin
        load_q_valid = 1'b1;
        case (r_q)
            tqrr_pkg::Q_FIRST:   load_pick = first_pick(r_present[0], r_hint);
            tqrr_pkg::Q_SECOND:  load_pick = lowest_free(r_present[1],
                                                         tqrr_pkg::PLAYER_QUEUE_SLOTS);
            tqrr_pkg::Q_NEUTRAL: load_pick = lowest_free(r_present[2], S);
            default: begin
                load_pick    = '0;
                load_q_valid = 1'b0;
            end
        endcase
        row_after = r_present[0] | (S'(1) << load_pick.slot);
        hint_pick = first_pick(row_after, tqrr_pkg::HINT_W'(load_pick.slot));
        hint_next = hint_pick.found ? tqrr_pkg::HINT_W'(hint_pick.slot)
                                    : tqrr_pkg::HINT_W'(load_pick.slot);
        load_addr  = tqrr_pkg::slot_addr(r_q, load_pick.slot);
        load_write = i_cmd.load_place && load_q_valid && load_pick.found;
    end

    // Probe of the schedule walk.
    logic [tqrr_pkg::SLOT_W-1:0]  probe_ni;
    logic [tqrr_pkg::SLOT_W-1:0]  probe_ni_inc;
    logic [tqrr_pkg::QUEUE_W-1:0] probe_nq;
    logic                         probe_present;
    logic [tqrr_pkg::ADDR_W-1:0]  probe_addr;

    always_comb begin
        probe_ni      = r_next_idx[r_cur_q];
        probe_ni_inc  = (probe_ni == tqrr_pkg::SLOT_W'(S - 1)) ? '0
                        : probe_ni + tqrr_pkg::SLOT_W'(1);
        probe_nq      = (r_cur_q == tqrr_pkg::Q_NEUTRAL) ? tqrr_pkg::Q_FIRST
                        : r_cur_q + tqrr_pkg::QUEUE_W'(1);
        probe_present = r_present[r_cur_q][probe_ni];
        probe_addr    = tqrr_pkg::slot_addr(r_cur_q, probe_ni);
    end

    assign o_stat.halted        = r_halted;
    assign o_stat.is_load       = (r_op == tqrr_pkg::OP_LOAD);
    assign o_stat.probe_present = probe_present;
    assign o_stat.limit_hit     = (r_probes == tqrr_pkg::PROBE_W'(tqrr_pkg::PROBE_LIMIT));
    assign o_stat.differs       = (r_rd_sel != r_old_sel) || (r_rd_pb != r_old_pb);
    assign o_stat.out_busy      = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (load_write) begin
            r_mem_sel[load_addr] <= r_sel;
            r_mem_pb[load_addr]  <= r_pb;
        end
        if (i_cmd.probe) begin
            r_rd_sel <= r_mem_sel[probe_addr];
            r_rd_pb  <= r_mem_pb[probe_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_next_idx  <= '0;
            r_cur_q     <= tqrr_pkg::Q_NEUTRAL;
            r_run_sel   <= tqrr_pkg::SEL_W'(tqrr_pkg::IDLE_SELECTOR);
            r_run_pb    <= '0;
            r_hint      <= '0;
            r_halted    <= 1'b0;
            r_probes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_probes <= '0;
            end
            if (load_write) begin
                r_present[r_q][load_pick.slot] <= 1'b1;
                if (r_q == tqrr_pkg::Q_FIRST) begin
                    r_hint <= hint_next;
                end
            end
            if (i_cmd.probe) begin
                r_next_idx[r_cur_q] <= probe_ni_inc;
                r_probes <= r_probes + tqrr_pkg::PROBE_W'(1);
                if (probe_present || (r_noted == probe_ni_inc)) begin
                    r_cur_q <= probe_nq;
                end
            end
            if (i_cmd.compare) begin
                r_run_sel <= r_rd_sel;
                r_run_pb  <= r_rd_pb;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op         <= i_opcode;
            r_q          <= i_queue_select;
            r_sel        <= i_task_selector;
            r_pb         <= i_page_base;
            r_old_sel    <= r_run_sel;
            r_old_pb     <= r_run_pb;
            r_noted      <= r_next_idx[r_cur_q];
            r_res_sel    <= '0;
            r_res_slot   <= '0;
            r_res_status <= tqrr_pkg::ST_OK;
        end
        if (i_cmd.res_halt || i_cmd.halt) begin
            r_res_sel    <= '0;
            r_res_status <= tqrr_pkg::ST_ERR;
        end
        if (i_cmd.load_place && load_q_valid) begin
            if (load_pick.found) begin
                r_res_slot <= load_pick.slot;
            end else begin
                r_res_status <= tqrr_pkg::ST_FULL;
            end
        end
        // The noted index only follows the walk when an empty slot wraps a queue.
        if (i_cmd.probe && !probe_present && (r_noted == probe_ni_inc)) begin
            r_noted <= r_next_idx[probe_nq];
        end
        if (i_cmd.compare) begin
            r_res_sel <= r_rd_sel;
        end
        if (i_cmd.emit) begin
            r_out_sel    <= r_res_sel;
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_chosen_selector = r_out_sel;
    assign o_slot_used       = tqrr_pkg::SLOT_OUT_W'(r_out_slot);
    assign o_status          = r_out_status;

endmodule

### rtl/three_queue_round_robin_task_scheduler_unit.sv
// Three-queue round-robin task scheduler. One item in, one result out,
// one item at a time. A load item is accepted, decoded and placed, and
// its result is moved into the output register. A schedule item walks
// the queues probe by probe; a present slot's stored task is read from
// the slot memory in its probe and compared in the following cycle. The
// walk is bounded by 46 probes, and a walk that reaches the bound sets
// the halt. Presence bits are flip-flops cleared by reset, so no
// clearing pass is needed. The output is registered, and a new item is
// accepted while a result waits.
// Depends on tqrr_pkg, tqrr_if, tqrr_ctrl and tqrr_dp.
module three_queue_round_robin_task_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tqrr_in_if.sink     i_task,
    tqrr_out_if.source  o_result
);

    tqrr_pkg::t_dp_cmd  cmd;
    tqrr_pkg::t_dp_stat stat;
    logic               in_ready;

    assign i_task.ready = in_ready;

    tqrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_task.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tqrr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (i_task.opcode),
        .i_queue_select    (i_task.queue_select),
        .i_task_selector   (i_task.task_selector),
        .i_page_base       (i_task.page_base),
        .o_out_valid       (o_result.valid),
        .i_out_ready       (o_result.ready),
        .o_chosen_selector (o_result.chosen_selector),
        .o_slot_used       (o_result.slot_used),
        .o_status          (o_result.status)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the three-queue round-robin task scheduler.
// A directed table and then random load and schedule items are checked against
// an in-bench prediction of the scheduler. Depends on tqrr_pkg, tqrr_if, the RTL.
`timescale 1ns / 100ps

module tb;
    import tqrr_pkg::*;

    localparam logic [QUEUE_W-1:0] Q_NONE = 2'd3;  // queue code the block ignores
    localparam int DIRECTED_COUNT   = 25;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int PHASE_COUNT      = 4;
    localparam int DRAIN_CYCLES     = 120;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [SEL_W-1:0]      chosen;
        logic [SLOT_OUT_W-1:0] slot;
        logic [STATUS_W-1:0]   status;
    } sched_result_t;

    typedef struct {
        logic               op;
        logic [QUEUE_W-1:0] q;
        logic [SEL_W-1:0]   sel;
        logic [PB_W-1:0]    pb;
        bit                 fixed;
        sched_result_t      want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    sched_result_t pending_results[$];

    // Scheduler state as the block should hold it.
    bit                 occupied [TOTAL_SLOTS];
    logic [SEL_W-1:0]   stored_sel [TOTAL_SLOTS];
    logic [PB_W-1:0]    stored_pb [TOTAL_SLOTS];
    logic [SLOT_W-1:0]  walk_pos [QUEUE_COUNT] = '{default: '0};
    logic [QUEUE_W-1:0] turn_queue = Q_NEUTRAL;
    logic [SEL_W-1:0]   active_sel = SEL_W'(IDLE_SELECTOR);
    logic [PB_W-1:0]    active_pb = '0;
    logic [HINT_W-1:0]  q0_hint = '0;
    bit                 is_halted = 1'b0;

    // Rows with a typed result are checked against it; the rest against the prediction.
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{OP_LOAD,  Q_NONE,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{16'h0, 4'd0, ST_OK}},
        '{OP_LOAD,  Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_LOAD,  Q_FIRST,   16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_LOAD,  Q_FIRST,   16'h1234, 32'h0001_1000, 1'b0, '0},
        '{OP_LOAD,  Q_FIRST,   16'h5678, 32'h0001_2000, 1'b0, '0},
        '{OP_LOAD,  Q_FIRST,   16'h9ABC, 32'h0001_3000, 1'b0, '0},
        '{OP_LOAD,  Q_FIRST,   16'h0001, 32'h0000_0001, 1'b1, '{16'h0, 4'd0, ST_FULL}},
        '{OP_LOAD,  Q_SECOND,  16'h0050, 32'h0000_0000, 1'b0, '0},
        '{OP_LOAD,  Q_SECOND,  16'h0050, 32'h0000_0001, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_LOAD,  Q_NEUTRAL, 16'hAAAA, 32'h5555_5555, 1'b0, '0},
        '{OP_LOAD,  Q_NEUTRAL, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_LOAD,  Q_SECOND,  16'h0050, 32'h0000_0000, 1'b0, '0},
        '{OP_LOAD,  Q_SECOND,  16'h00FF, 32'h0000_FFFF, 1'b0, '0},
        '{OP_LOAD,  Q_SECOND,  16'hFF00, 32'hFFFF_0000, 1'b0, '0},
        '{OP_LOAD,  Q_SECOND,  16'h0002, 32'h0000_0002, 1'b1, '{16'h0, 4'd0, ST_FULL}},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_LOAD,  Q_NONE,    16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 4'd0, ST_OK}},
        '{OP_SCHED, Q_NONE,    16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0},
        '{OP_SCHED, Q_FIRST,   16'h0000, 32'h0000_0000, 1'b0, '0}
    };

    tqrr_in_if  task_ch ();
    tqrr_out_if result_ch ();

    three_queue_round_robin_task_scheduler_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_task   (task_ch),
        .o_result (result_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int free_slot_below(int q, int lim);
        for (int k = 0; k < lim && k < SLOTS_PER_QUEUE; k++)
            if (!occupied[q * SLOTS_PER_QUEUE + k])
                return k;
        return -1;
    endfunction

    // The first queue prefers the slot after its hint.
    function automatic int first_queue_slot();
        int pref;
        pref = (int'(q0_hint) + 1) % PLAYER_QUEUE_SLOTS;
        if (!occupied[pref])
            return pref;
        return free_slot_below(0, PLAYER_QUEUE_SLOTS);
    endfunction

    function automatic sched_result_t predict_item(logic op, logic [QUEUE_W-1:0] q,
                                                   logic [SEL_W-1:0] sel,
                                                   logic [PB_W-1:0] pb);
        sched_result_t    res;
        int               slot, nxt, idx, cq, probes, noted;
        logic [SEL_W-1:0] prev_sel;
        logic [PB_W-1:0]  prev_pb;
        res = '0;
        if (is_halted) begin
            res.status = ST_ERR;
            return res;
        end
        if (op == OP_LOAD) begin
            if (q == Q_NONE)
                return res;
            case (q)
                Q_FIRST:  slot = first_queue_slot();
                Q_SECOND: slot = free_slot_below(1, PLAYER_QUEUE_SLOTS);
                default:  slot = free_slot_below(2, SLOTS_PER_QUEUE);
            endcase
            if (slot < 0) begin
                res.status = ST_FULL;
                return res;
            end
            idx = int'(q) * SLOTS_PER_QUEUE + slot;
            occupied[idx] = 1'b1;
            stored_sel[idx] = sel;
            stored_pb[idx] = pb;
            if (q == Q_FIRST) begin
                q0_hint = HINT_W'(slot);
                nxt = first_queue_slot();
                if (nxt >= 0)
                    q0_hint = HINT_W'(nxt);
            end
            res.slot = SLOT_OUT_W'(slot);
            return res;
        end

        prev_sel = active_sel;
        prev_pb = active_pb;
        noted = int'(walk_pos[turn_queue]);
        probes = 0;
        // A present slot equal to the old task is taken but does not end the walk.
        while (active_sel == prev_sel && active_pb == prev_pb) begin
            if (probes >= PROBE_LIMIT) begin
                is_halted = 1'b1;
                res = '0;
                res.status = ST_ERR;
                return res;
            end
            cq = int'(turn_queue);
            idx = cq * SLOTS_PER_QUEUE + int'(walk_pos[cq]);
            walk_pos[cq] = SLOT_W'((int'(walk_pos[cq]) + 1) % SLOTS_PER_QUEUE);
            if (occupied[idx]) begin
                res.chosen = stored_sel[idx];
                active_sel = stored_sel[idx];
                active_pb = stored_pb[idx];
                turn_queue = QUEUE_W'((cq + 1) % QUEUE_COUNT);
            end else if (noted == int'(walk_pos[cq])) begin
                turn_queue = QUEUE_W'((cq + 1) % QUEUE_COUNT);
                noted = int'(walk_pos[turn_queue]);
            end
            probes++;
        end
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [QUEUE_W-1:0] q,
                             input logic [SEL_W-1:0] sel, input logic [PB_W-1:0] pb,
                             input bit fixed, input sched_result_t want);
        sched_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            task_ch.valid <= 1'b0;
            @(posedge clk);
        end
        task_ch.valid         <= 1'b1;
        task_ch.opcode        <= op;
        task_ch.queue_select  <= q;
        task_ch.task_selector <= sel;
        task_ch.page_base     <= pb;
        @(posedge clk);
        while (!task_ch.ready)
            @(posedge clk);
        predicted = predict_item(op, q, sel, pb);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    always @(posedge clk) begin : result_check
        sched_result_t got, want;
        result_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (result_ch.valid && result_ch.ready) begin
            got.chosen = result_ch.chosen_selector;
            got.slot   = result_ch.slot_used;
            got.status = result_ch.status;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("tb: result with nothing pending: sel %h slot %0d status %0d",
                             got.chosen, got.slot, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.chosen !== want.chosen || got.slot !== want.slot
                        || got.status !== want.status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("tb: mismatch: expected sel %h slot %0d status %0d, %s",
                                 want.chosen, want.slot, want.status,
                                 $sformatf("got sel %h slot %0d status %0d",
                                           got.chosen, got.slot, got.status));
                end
            end
        end
    end

    initial begin
        logic [SEL_W+PB_W-1:0] seen_tasks[$];
        logic                  op;
        logic [QUEUE_W-1:0]    q;
        logic [SEL_W-1:0]      sel;
        logic [PB_W-1:0]       pb;
        int unsigned           counted, pick;

        task_ch.valid         = 1'b0;
        task_ch.opcode        = OP_LOAD;
        task_ch.queue_select  = Q_FIRST;
        task_ch.task_selector = '0;
        task_ch.page_base     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].q, directed_rows[i].sel,
                      directed_rows[i].pb, directed_rows[i].fixed, directed_rows[i].want);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            counted = 0;
            while (counted < RANDOM_PER_PHASE) begin
                op = ($urandom_range(99) < 55) ? OP_SCHED : OP_LOAD;
                pick = $urandom_range(19);
                q = (pick == 0) ? Q_NONE : QUEUE_W'(pick % QUEUE_COUNT);
                // Reloading a known task puts duplicates in the queues for the walk to skip.
                if (seen_tasks.size() != 0 && $urandom_range(2) == 0) begin
                    {sel, pb} = seen_tasks[$urandom_range(seen_tasks.size() - 1)];
                end else begin
                    sel = SEL_W'($urandom);
                    pb  = $urandom;
                end
                if (op == OP_LOAD && q != Q_NONE)
                    seen_tasks.push_back({sel, pb});
                send_item(op, q, sel, pb, 1'b0, '0);
                if (!(op == OP_LOAD && q == Q_NONE))
                    counted++;
            end
        end
        task_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
